/* sv/bkec_pkg.sv */
// Shared types and constants for the K(3,5) edge check block.
// Depends on nothing; imported by the controller, the datapath and the top level.
package bkec_pkg;

    // Width of each configuration register and of the register index.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    // Width of the row and column fields of an input item.
    localparam int FIELD_W   = 6;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE      = 2'd0,
        CFG_COLS_IN_USE      = 2'd1,
        CFG_COMMON_THRESHOLD = 2'd2
    } cfg_idx_t;

    // Input item kinds.
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // Source of the adjacency memory read address.
    typedef enum logic [1:0] {
        ADJ_SEL_ROW  = 2'd0,
        ADJ_SEL_SCAN = 2'd1,
        ADJ_SEL_CAND = 2'd2
    } adj_sel_t;

    typedef enum logic [3:0] {
        S_IDLE    = 4'd0,
        S_DONE    = 4'd1,
        S_WR_RD   = 4'd2,
        S_WR_WB   = 4'd3,
        S_RU_RD   = 4'd4,
        S_RU_WAIT = 4'd5,
        S_SC_RD   = 4'd6,
        S_SC_EVAL = 4'd7,
        S_SC_END  = 4'd8,
        S_IC_RD   = 4'd9,
        S_IR_RD   = 4'd10,
        S_IP      = 4'd11,
        S_JC_RD   = 4'd12,
        S_JR_RD   = 4'd13,
        S_JG      = 4'd14,
        S_JS      = 4'd15
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     latch;
        adj_sel_t adj_sel;
        logic     adj_we;
        logic     load_ru;
        logic     scan_clear;
        logic     scan_eval;
        logic     load_pi;
        logic     load_gc;
        logic     ii_inc;
        logic     jj_inc;
        logic     cand_sel_j;
        logic     res_load;
        logic     res_val;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind_in;
        logic oob_in;
        logic rows_zero;
        logic scan_last;
        logic nc_lt2;
        logic hit;
        logic j_more;
        logic i_more;
    } stat_t;

endpackage

/* sv/bkec_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module bkec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/bkec_ctrl.sv */
// Controller state machine for the K(3,5) edge check block.
// Depends on bkec_pkg; drives the datapath through cmd_t and reads stat_t.
module bkec_ctrl import bkec_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = !(state_reg inside {S_IDLE, S_DONE});
    assign done   = (state_reg == S_DONE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                state_next = S_IDLE;
                if (accept)
                begin
                    if (stat.oob_in)
                    begin
                        state_next = stat.kind_in ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        state_next = stat.kind_in ? S_RU_RD : S_WR_RD;
                    end
                end
            end
            S_WR_RD:   state_next = S_WR_WB;
            S_WR_WB:   state_next = S_IDLE;
            S_RU_RD:   state_next = S_RU_WAIT;
            S_RU_WAIT: state_next = stat.rows_zero ? S_DONE : S_SC_RD;
            S_SC_RD:   state_next = S_SC_EVAL;
            S_SC_EVAL: state_next = stat.scan_last ? S_SC_END : S_SC_RD;
            S_SC_END:  state_next = stat.nc_lt2 ? S_DONE : S_IC_RD;
            S_IC_RD:   state_next = S_IR_RD;
            S_IR_RD:   state_next = S_IP;
            S_IP:      state_next = S_JC_RD;
            S_JC_RD:   state_next = S_JR_RD;
            S_JR_RD:   state_next = S_JG;
            S_JG:      state_next = S_JS;
            S_JS:
            begin
                if (stat.hit)
                begin
                    state_next = S_DONE;
                end
                else if (stat.j_more)
                begin
                    state_next = S_JC_RD;
                end
                else if (stat.i_more)
                begin
                    state_next = S_IC_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        cmd.adj_sel = ADJ_SEL_ROW;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (accept)
                begin
                    cmd.latch = 1'b1;
                    if (stat.kind_in && stat.oob_in)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_val  = 1'b0;
                    end
                end
            end
            S_WR_WB:   cmd.adj_we = 1'b1;
            S_RU_WAIT:
            begin
                cmd.load_ru    = 1'b1;
                cmd.scan_clear = 1'b1;
                cmd.res_load   = stat.rows_zero;
            end
            S_SC_RD:   cmd.adj_sel = ADJ_SEL_SCAN;
            S_SC_EVAL: cmd.scan_eval = 1'b1;
            S_SC_END:  cmd.res_load = stat.nc_lt2;
            S_IR_RD:   cmd.adj_sel = ADJ_SEL_CAND;
            S_IP:      cmd.load_pi = 1'b1;
            S_JC_RD:   cmd.cand_sel_j = 1'b1;
            S_JR_RD:
            begin
                cmd.cand_sel_j = 1'b1;
                cmd.adj_sel    = ADJ_SEL_CAND;
            end
            S_JG:      cmd.load_gc = 1'b1;
            S_JS:
            begin
                if (stat.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_val  = 1'b1;
                end
                else if (stat.j_more)
                begin
                    cmd.jj_inc = 1'b1;
                end
                else if (stat.i_more)
                begin
                    cmd.ii_inc = 1'b1;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                end
            end
            default:   cmd.adj_sel = ADJ_SEL_ROW;
        endcase
    end

endmodule

/* sv/bkec_dp.sv */
// Datapath for the K(3,5) edge check: config registers, adjacency and candidate RAMs,
// scan and pair counters, popcount. Depends on bkec_pkg and bkec_ram.
module bkec_dp import bkec_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 kind,
    input  logic [FIELD_W-1:0]   row_index,
    input  logic [FIELD_W-1:0]   col_index,
    input  logic                 edge_value,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 creates_biclique
);

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int GROUPS = (MAX_VERTICES + 7) / 8;
    localparam int PAD_W  = GROUPS * 8;
    localparam logic [CMP_W-1:0] MAXV_C = CMP_W'(MAX_VERTICES);

    function automatic logic [3:0] popcount8(input logic [7:0] x);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < 8; b++)
        begin
            n = n + {3'b000, x[b]};
        end
        return n;
    endfunction

    logic [CFG_W-1:0]        rows_reg;
    logic [CFG_W-1:0]        cols_reg;
    logic [CFG_W-1:0]        thr_reg;
    logic [FIELD_W-1:0]      row_reg;
    logic [FIELD_W-1:0]      col_reg;
    logic                    value_reg;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic                    rv_reg;
    logic [MAX_VERTICES-1:0] ru_reg;
    logic [MAX_VERTICES-1:0] pi_reg;
    logic [3:0]              gc_reg [GROUPS];
    logic [CNT_W-1:0]        scan_reg;
    logic [CNT_W-1:0]        nc_reg;
    logic [CNT_W-1:0]        ii_reg;
    logic [CNT_W-1:0]        jj_reg;
    logic                    result_reg;

    logic [CNT_W-1:0]        rows_eff;
    logic [CNT_W-1:0]        cols_eff;
    logic [CMP_W-1:0]        need_ext;
    logic [IDX_W-1:0]        adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic [MAX_VERTICES-1:0] row_eff;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [MAX_VERTICES-1:0] col_mask;
    logic [IDX_W-1:0]        cand_raddr;
    logic [IDX_W-1:0]        cand_rdata;
    logic                    is_cand;
    logic [PAD_W-1:0]        and_pad;
    logic [CNT_W-1:0]        total;
    logic [IDX_W-1:0]        v_idx;

    // Clamp sizes to the matrix, threshold zero acts as one
    always_comb
    begin
        rows_eff = (CMP_W'(rows_reg) > MAXV_C) ? CNT_W'(MAX_VERTICES) : CNT_W'(rows_reg);
        cols_eff = (CMP_W'(cols_reg) > MAXV_C) ? CNT_W'(MAX_VERTICES) : CNT_W'(cols_reg);
        need_ext = (thr_reg == '0) ? CMP_W'(1) : CMP_W'(thr_reg);
    end

    assign v_idx = IDX_W'(col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(64);
            cols_reg <= CFG_W'(64);
            thr_reg  <= CFG_W'(4);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_IN_USE:      rows_reg <= cfg_data;
                CFG_COLS_IN_USE:      cols_reg <= cfg_data;
                CFG_COMMON_THRESHOLD: thr_reg  <= cfg_data;
                default:              thr_reg  <= thr_reg;
            endcase
        end
    end

    // Latched item; payload only
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            row_reg   <= row_index;
            col_reg   <= col_index;
            value_reg <= edge_value;
        end
    end

    // Adjacency memory, one row per entry; rows never written read as zero
    always_comb
    begin
        case (cmd.adj_sel)
            ADJ_SEL_ROW:  adj_raddr = IDX_W'(row_reg);
            ADJ_SEL_SCAN: adj_raddr = scan_reg[IDX_W-1:0];
            ADJ_SEL_CAND: adj_raddr = cand_rdata;
            default:      adj_raddr = IDX_W'(row_reg);
        endcase
    end

    assign row_eff = rv_reg ? adj_rdata : '0;

    always_comb
    begin
        adj_wdata        = row_eff;
        adj_wdata[v_idx] = value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            rv_reg <= valid_reg[adj_raddr];
            if (cmd.adj_we)
            begin
                valid_reg[IDX_W'(row_reg)] <= 1'b1;
            end
        end
    end

    bkec_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (cmd.adj_we),
        .waddr (IDX_W'(row_reg)),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // Candidate list
    assign is_cand    = row_eff[v_idx] && (CMP_W'(scan_reg) != CMP_W'(row_reg));
    assign cand_raddr = cmd.cand_sel_j ? jj_reg[IDX_W-1:0] : ii_reg[IDX_W-1:0];

    bkec_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_VERTICES)
    ) u_cand_ram (
        .clk   (clk),
        .we    (cmd.scan_eval && is_cand),
        .waddr (nc_reg[IDX_W-1:0]),
        .wdata (scan_reg[IDX_W-1:0]),
        .raddr (cand_raddr),
        .rdata (cand_rdata)
    );

    // Columns that count: below cols in use, never column v
    always_comb
    begin
        for (int k = 0; k < MAX_VERTICES; k++)
        begin
            col_mask[k] = (k < int'(cols_eff)) && (k != int'(v_idx));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            nc_reg   <= '0;
            ii_reg   <= '0;
            jj_reg   <= '0;
        end
        else
        begin
            if (cmd.scan_clear)
            begin
                scan_reg <= '0;
                nc_reg   <= '0;
                ii_reg   <= '0;
            end
            if (cmd.scan_eval)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (is_cand)
                begin
                    nc_reg <= nc_reg + 1'b1;
                end
            end
            if (cmd.ii_inc)
            begin
                ii_reg <= ii_reg + 1'b1;
            end
            if (cmd.load_pi)
            begin
                jj_reg <= ii_reg + 1'b1;
            end
            else if (cmd.jj_inc)
            begin
                jj_reg <= jj_reg + 1'b1;
            end
        end
    end

    // Row masks and per-byte popcounts
    assign and_pad = PAD_W'(pi_reg & row_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.load_ru)
        begin
            ru_reg <= row_eff & col_mask;
        end
        if (cmd.load_pi)
        begin
            pi_reg <= ru_reg & row_eff;
        end
        if (cmd.load_gc)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                gc_reg[g] <= popcount8(and_pad[g*8 +: 8]);
            end
        end
        if (cmd.res_load)
        begin
            result_reg <= cmd.res_val;
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total = total + CNT_W'(gc_reg[g]);
        end
    end

    // Status
    always_comb
    begin
        stat.kind_in   = (kind == KIND_QUERY);
        stat.oob_in    = (CMP_W'(row_index) >= MAXV_C) || (CMP_W'(col_index) >= MAXV_C);
        stat.rows_zero = (rows_eff == '0);
        stat.scan_last = (({1'b0, scan_reg} + 1'b1) >= {1'b0, rows_eff});
        stat.nc_lt2    = (nc_reg < CNT_W'(2));
        stat.hit       = (CMP_W'(total) >= need_ext);
        stat.j_more    = (({1'b0, jj_reg} + 1'b1) < {1'b0, nc_reg});
        stat.i_more    = (({1'b0, ii_reg} + (CNT_W + 1)'(2)) < {1'b0, nc_reg});
    end

    assign creates_biclique = result_reg;

endmodule

/* sv/biclique_k35_edge_check.sv */
// Top level of the K(3,5) edge check block: controller plus datapath.
// Depends on bkec_pkg, bkec_ctrl, bkec_dp (and bkec_ram through the datapath).
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high and busy low.
//   kind selects an edge write (store edge_value at row_index, col_index) or a query
//   asking whether edge (row_index, col_index) would close a K(3,5).
//   A write gives no result and occupies the block through its read and write-back states.
//   A query gives exactly one result: done is high for one cycle with creates_biclique
//   valid. The receiver cannot stall; the result must be taken in that cycle. A new
//   item may transfer in the done cycle itself.
//   A query reads the item's row, scans the rows in use to build the candidate list,
//   then tests candidate pairs until a hit or all pairs are tested; an out-of-range query
//   answers in the next cycle. The pair loop walks the candidate list through the
//   single read port of the adjacency RAM, reading one candidate row per pair tested.
//   Configuration: a separate write channel (cfg_valid, cfg_ready, cfg_index,
//   cfg_data); cfg_ready is always high. Write only while the block is idle.
//   Reset: asynchronous, active low. Registers take their defaults (64, 64, 4) and
//   every matrix row reads as clear through per-row valid flags; no clearing pass.
module biclique_k35_edge_check import bkec_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [FIELD_W-1:0]   row_index,
    input  logic [FIELD_W-1:0]   col_index,
    input  logic                 edge_value,
    output logic                 done,
    output logic                 creates_biclique,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Config writes always transfer at once
    assign cfg_ready = 1'b1;

    bkec_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bkec_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .kind             (kind),
        .row_index        (row_index),
        .col_index        (col_index),
        .edge_value       (edge_value),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .creates_biclique (creates_biclique)
    );

`ifndef SYNTHESIS
    // An accepted edge write is not followed by a result strobe
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !kind) |=> !done)
        else $error("edge write produced a result");

    // An out-of-range query answers 0 in the next cycle
    a_oob_query: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind &&
         ((row_index >= MAX_VERTICES) || (col_index >= MAX_VERTICES)))
        |=> (done && !creates_biclique))
        else $error("out-of-range query not answered with 0");

    // An in-range query keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind &&
         (row_index < MAX_VERTICES) && (col_index < MAX_VERTICES))
        |=> (busy && !done))
        else $error("in-range query did not occupy the block");

    // The result strobe never coincides with busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");
`endif

endmodule
